/* rtl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// Particle store update package
// Shared types, codes and constants of the particle store with Euler update.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MaxParticlesDef = 64;
  localparam int CntW = 7;

  typedef enum logic {
    OP_SPAWN = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_REPORT     = 2'd0,
    ST_SPAWN_OK   = 2'd1,
    ST_SPAWN_FULL = 2'd2,
    ST_TICK_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_FORCE_X = 2'd0,
    CFG_FORCE_Y = 2'd1,
    CFG_FORCE_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT_OK,
    S_EMIT_FULL,
    S_EMIT_EMPTY,
    S_W_RD,
    S_W_M1,
    S_W_M2,
    S_W_M3,
    S_W_WB,
    S_R_RD,
    S_R_OUT
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] size_init;
    logic signed [31:0] size_rate;
    logic signed [31:0] angle_init;
    logic signed [31:0] angle_rate;
    logic        [30:0] life_or_dt;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_size;
    logic signed [31:0] out_angle;
    logic        [30:0] out_life;
    logic [CntW-1:0]    live_count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] size;
    logic signed [31:0] size_rate;
    logic signed [31:0] angle;
    logic signed [31:0] angle_rate;
    logic        [30:0] life;
  } particle_t;

  typedef struct packed {
    logic    latch_in;
    logic    spawn_wr;
    logic    walk_start;
    logic    rd_walk;
    logic    mul1;
    logic    mul2;
    logic    mul3;
    logic    wb;
    logic    walk_end;
    logic    rd_rpt;
    logic    emit_rpt;
    logic    emit_sts;
    status_e emit_code;
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic full;
    logic walk_done;
    logic w_zero;
    logic rpt_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/psu_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one spawn or tick item.
// ----------------------------------------------------------------------------
interface psu_in_if import psu_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

/* rtl/psu_out_if.sv */
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface psu_out_if import psu_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

/* rtl/psu_ctrl.sv */
// ----------------------------------------------------------------------------
// Particle store controller
// Sequences spawns, the update walk over the store and the report walk.
// ----------------------------------------------------------------------------
module psu_ctrl import psu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts_i.op_tick) state_d = S_W_RD;
        else if (sts_i.full) state_d = S_EMIT_FULL;
        else state_d = S_EMIT_OK;
      end
      S_EMIT_OK, S_EMIT_FULL, S_EMIT_EMPTY: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_W_RD: begin
        if (!sts_i.walk_done) state_d = S_W_M1;
        else if (sts_i.w_zero) state_d = S_EMIT_EMPTY;
        else state_d = S_R_RD;
      end
      S_W_M1: state_d = S_W_M2;
      S_W_M2: state_d = S_W_M3;
      S_W_M3: state_d = S_W_WB;
      S_W_WB: state_d = S_W_RD;
      S_R_RD: state_d = S_R_OUT;
      S_R_OUT: begin
        if (sts_i.out_free) state_d = sts_i.rpt_last ? S_IDLE : S_R_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_code = ST_REPORT;
    in_ready_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      S_DISPATCH: begin
        cmd_o.walk_start = sts_i.op_tick;
        cmd_o.spawn_wr   = !sts_i.op_tick && !sts_i.full;
      end
      S_EMIT_OK: begin
        cmd_o.emit_sts  = sts_i.out_free;
        cmd_o.emit_code = ST_SPAWN_OK;
      end
      S_EMIT_FULL: begin
        cmd_o.emit_sts  = sts_i.out_free;
        cmd_o.emit_code = ST_SPAWN_FULL;
      end
      S_EMIT_EMPTY: begin
        cmd_o.emit_sts  = sts_i.out_free;
        cmd_o.emit_code = ST_TICK_EMPTY;
      end
      S_W_RD: begin
        cmd_o.rd_walk  = !sts_i.walk_done;
        cmd_o.walk_end = sts_i.walk_done;
      end
      S_W_M1: cmd_o.mul1 = 1'b1;
      S_W_M2: cmd_o.mul2 = 1'b1;
      S_W_M3: cmd_o.mul3 = 1'b1;
      S_W_WB: cmd_o.wb = 1'b1;
      S_R_RD: cmd_o.rd_rpt = 1'b1;
      S_R_OUT: cmd_o.emit_rpt = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/psu_dp.sv */
// ----------------------------------------------------------------------------
// Particle store datapath
// Particle memory, walk counters, Euler arithmetic and the result register.
// ----------------------------------------------------------------------------
module psu_dp import psu_pkg::*; #(
  parameter int MAX_PARTICLES = MaxParticlesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output sts_t         sts_o,
  input  in_item_t     in_item_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_item_o
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  // Floor of (a * dt) / 2^16; dropping low bits of the product is a floor.
  function automatic logic signed [47:0] mul_dt(logic signed [31:0] a, logic [30:0] dt);
    logic signed [63:0] p;
    p = a * $signed({1'b0, dt});
    return p[63:16];
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] x,
                                                 logic signed [47:0] p);
    logic signed [48:0] s;
    s = {{17{x[31]}}, x} + {p[47], p};
    if (!s[48] && (|s[47:31])) return 32'sh7fffffff;
    else if (s[48] && !(&s[47:31])) return 32'sh80000000;
    else return s[31:0];
  endfunction

  logic signed [31:0] force_x_q, force_y_q, force_z_q;
  in_item_t           in_q;
  logic [CntW-1:0]    count_q, i_q, w_q, j_q;

  particle_t          mem [MAX_PARTICLES];
  particle_t          rd_q;
  particle_t          wdata;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic               re;

  logic signed [47:0] pf_x_q, pf_y_q, pf_z_q, ps_q, pa_q;
  logic signed [47:0] pv_x_q, pv_y_q, pv_z_q;
  logic signed [31:0] v_x_q, v_y_q, v_z_q, size_n_q, angle_n_q;
  logic        [30:0] life_n_q;
  logic               alive_q;
  logic        [31:0] life_diff;

  logic               out_valid_q;
  out_item_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_x_q <= '0;
      force_y_q <= '0;
      force_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORCE_X: force_x_q <= cfg_data_i;
        CFG_FORCE_Y: force_y_q <= cfg_data_i;
        CFG_FORCE_Z: force_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) in_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q     <= '0;
      w_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.spawn_wr) count_q <= count_q + 1'b1;
      if (cmd_i.walk_start) begin
        i_q <= '0;
        w_q <= '0;
      end
      if (cmd_i.wb) begin
        i_q <= i_q + 1'b1;
        if (alive_q) w_q <= w_q + 1'b1;
      end
      if (cmd_i.walk_end) begin
        count_q <= w_q;
        j_q     <= '0;
      end
      if (cmd_i.emit_rpt) j_q <= j_q + 1'b1;
    end
  end

  // Write port: a spawn appends at the fill count, a survivor is compacted to w.
  always_comb begin
    we    = cmd_i.spawn_wr || (cmd_i.wb && alive_q);
    waddr = cmd_i.spawn_wr ? count_q[AW-1:0] : w_q[AW-1:0];
    if (cmd_i.spawn_wr) begin
      wdata.pos_x      = in_q.pos_x;
      wdata.pos_y      = in_q.pos_y;
      wdata.pos_z      = in_q.pos_z;
      wdata.vel_x      = in_q.vel_x;
      wdata.vel_y      = in_q.vel_y;
      wdata.vel_z      = in_q.vel_z;
      wdata.size       = in_q.size_init;
      wdata.size_rate  = in_q.size_rate;
      wdata.angle      = in_q.angle_init;
      wdata.angle_rate = in_q.angle_rate;
      wdata.life       = in_q.life_or_dt;
    end else begin
      wdata.pos_x      = sat_add(rd_q.pos_x, pv_x_q);
      wdata.pos_y      = sat_add(rd_q.pos_y, pv_y_q);
      wdata.pos_z      = sat_add(rd_q.pos_z, pv_z_q);
      wdata.vel_x      = v_x_q;
      wdata.vel_y      = v_y_q;
      wdata.vel_z      = v_z_q;
      wdata.size       = size_n_q;
      wdata.size_rate  = rd_q.size_rate;
      wdata.angle      = angle_n_q;
      wdata.angle_rate = rd_q.angle_rate;
      wdata.life       = life_n_q;
    end
    re    = cmd_i.rd_walk || cmd_i.rd_rpt;
    raddr = cmd_i.rd_rpt ? j_q[AW-1:0] : i_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  assign life_diff = {1'b0, rd_q.life} - {1'b0, in_q.life_or_dt};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      alive_q  <= !life_diff[31];
      life_n_q <= life_diff[30:0];
      pf_x_q   <= mul_dt(force_x_q, in_q.life_or_dt);
      pf_y_q   <= mul_dt(force_y_q, in_q.life_or_dt);
      pf_z_q   <= mul_dt(force_z_q, in_q.life_or_dt);
      ps_q     <= mul_dt(rd_q.size_rate, in_q.life_or_dt);
      pa_q     <= mul_dt(rd_q.angle_rate, in_q.life_or_dt);
    end
    if (cmd_i.mul2) begin
      v_x_q     <= sat_add(rd_q.vel_x, pf_x_q);
      v_y_q     <= sat_add(rd_q.vel_y, pf_y_q);
      v_z_q     <= sat_add(rd_q.vel_z, pf_z_q);
      size_n_q  <= sat_add(rd_q.size, ps_q);
      angle_n_q <= sat_add(rd_q.angle, pa_q);
    end
    if (cmd_i.mul3) begin
      pv_x_q <= mul_dt(v_x_q, in_q.life_or_dt);
      pv_y_q <= mul_dt(v_y_q, in_q.life_or_dt);
      pv_z_q <= mul_dt(v_z_q, in_q.life_or_dt);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_rpt || cmd_i.emit_sts) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rpt) begin
      out_q.status     <= ST_REPORT;
      out_q.out_pos_x  <= rd_q.pos_x;
      out_q.out_pos_y  <= rd_q.pos_y;
      out_q.out_pos_z  <= rd_q.pos_z;
      out_q.out_size   <= rd_q.size;
      out_q.out_angle  <= rd_q.angle;
      out_q.out_life   <= rd_q.life;
      out_q.live_count <= count_q;
      out_q.last       <= sts_o.rpt_last;
    end else if (cmd_i.emit_sts) begin
      out_q.status     <= cmd_i.emit_code;
      out_q.out_pos_x  <= '0;
      out_q.out_pos_y  <= '0;
      out_q.out_pos_z  <= '0;
      out_q.out_size   <= '0;
      out_q.out_angle  <= '0;
      out_q.out_life   <= '0;
      out_q.live_count <= count_q;
      out_q.last       <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    sts_o.op_tick   = (in_q.operation == OP_TICK);
    sts_o.full      = (count_q >= CntW'(MAX_PARTICLES));
    sts_o.walk_done = (i_q == count_q);
    sts_o.w_zero    = (w_q == '0);
    sts_o.rpt_last  = (CntW'(j_q + 1'b1) == count_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

/* rtl/particle_store_euler_update.sv */
// ----------------------------------------------------------------------------
// Particle store with Euler update
// Spawn: taken when idle, written at the fill count unless full; then a status
// result once the output is free. Tick: an update walk (one memory port and a
// three-step multiply chain per particle), then survivor reports or an empty
// status. One item at a time. Reset clears the count and forces; no sweep.
// ----------------------------------------------------------------------------
module particle_store_euler_update import psu_pkg::*; #(
  parameter int MAX_PARTICLES = MaxParticlesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psu_in_if.sink      in_i,
  psu_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // The controller and the datapath talk only through these two structs.
  cmd_t cmd;
  sts_t sts;

  // The controller takes an item only in its idle state, so the ready
  // signal doubles as the accept qualifier for the input latch.
  psu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath holds the particle memory, the update arithmetic and the
  // result register that lets a finished result wait for the sink.
  psu_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_i.item),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.item)
  );

  // The live count shown never goes beyond the store's capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.item.live_count <= CntW'(MAX_PARTICLES))
    else $error("live count beyond capacity");

  // Once an item is taken, the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken twice in a row");

  // A spawn write and a compacting write-back never share the write port.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.spawn_wr && cmd.wb))
    else $error("write port conflict");

  // Any result other than a particle report is the only result of its item.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.item.status != ST_REPORT) |-> out_o.item.last)
    else $error("status result without last");

endmodule
